FILE: sv/brl_pkg.sv
// Package with the shared widths, codes and payload types of the line rasterizer.
`default_nettype none

package brl_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned HOLD_BITS  = COORD_BITS + 1;
  localparam int unsigned STEP_BITS  = COORD_BITS + 2;
  localparam int unsigned DEC_BITS   = COORD_BITS + 3;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  typedef struct packed {
    action_e                      action;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
  } in_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last;
  } out_req_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cur_x;
    logic signed [COORD_BITS-1:0] cur_y;
    logic signed [DEC_BITS-1:0]   decision;
    logic [HOLD_BITS-1:0]         incr_hold;
    logic signed [STEP_BITS-1:0]  incr_step;
    logic [COORD_BITS-1:0]        remaining;
    logic                         x_major;
    logic                         x_dir_neg;
    logic                         y_dir_neg;
    logic                         active;
  } seg_state_t;

endpackage

`default_nettype wire

FILE: sv/bresenham_line_rasterizer.sv
// Top level of the Bresenham line rasterizer with its input and output registers.
// A request on the input channel is either a load (action 0), which latches a
// segment's start and end points and gives no result, or a step (action 1),
// which gives the next pixel of the loaded segment. A segment yields
// max(|dx|,|dy|) pixels starting at the start point; the end point is not drawn,
// and last marks the final pixel. A step with no segment left gives no result.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. A request is held in the input register while it is worked on,
// and its pixel is registered in the output register, which offers it on the output channel.
// One request is taken every cycle unless the input stalls; the rate is set by the single step unit.
// When the receiver stalls, the pixel waits in the output register; loads and
// steps that give nothing still drain behind it, and the input stalls only when
// a step with a pixel cannot reach the output register.
// Reset clears the segment state, so no segment is active afterwards.
`default_nettype none

module bresenham_line_rasterizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  brl_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output brl_pkg::out_req_t out_req_o
);

  logic              in_valid_q;
  brl_pkg::in_req_t  in_q;
  logic              out_valid_q;
  brl_pkg::out_req_t out_q;
  logic              out_free, emit, proc, accept;
  brl_pkg::out_req_t pixel;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && (!emit || out_free);
  assign in_stall_o = in_valid_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;

  brl_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (proc),
    .req_i   (in_q),
    .emit_o  (emit),
    .pixel_o (pixel)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && proc && emit) begin
      out_q <= pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && emit && out_valid_q && out_stall_i)
    else $error("Input stalled without a blocked pixel.");

  a_pixel_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && emit |-> out_free)
    else $error("Pixel issued into a full output register.");
`endif

endmodule

`default_nettype wire

FILE: sv/brl_setup.sv
// Segment setup: major axis, step signs, decision term and increments from two endpoints.
`default_nettype none

module brl_setup (
  input  brl_pkg::in_req_t    req_i,
  output brl_pkg::seg_state_t seg_o
);

  localparam int unsigned CW = brl_pkg::COORD_BITS;

  logic signed [CW:0]   xs_ext, ys_ext, xe_ext, ye_ext;
  logic signed [CW:0]   dx_fwd, dx_rev, dy_fwd, dy_rev;
  logic                 x_neg, y_neg, x_maj;
  logic [CW-1:0]        adx, ady, maj, mnr;

  assign xs_ext = {req_i.x_start[CW-1], req_i.x_start};
  assign ys_ext = {req_i.y_start[CW-1], req_i.y_start};
  assign xe_ext = {req_i.x_end[CW-1], req_i.x_end};
  assign ye_ext = {req_i.y_end[CW-1], req_i.y_end};

  assign dx_fwd = xe_ext - xs_ext;
  assign dx_rev = xs_ext - xe_ext;
  assign dy_fwd = ye_ext - ys_ext;
  assign dy_rev = ys_ext - ye_ext;

  assign x_neg = req_i.x_start > req_i.x_end;
  assign y_neg = req_i.y_start > req_i.y_end;
  assign adx   = x_neg ? dx_rev[CW-1:0] : dx_fwd[CW-1:0];
  assign ady   = y_neg ? dy_rev[CW-1:0] : dy_fwd[CW-1:0];
  assign x_maj = adx >= ady;
  assign maj   = x_maj ? adx : ady;
  assign mnr   = x_maj ? ady : adx;

  always_comb begin
    seg_o.cur_x     = req_i.x_start;
    seg_o.cur_y     = req_i.y_start;
    seg_o.decision  = {2'b00, mnr, 1'b0} - {3'b000, maj};
    seg_o.incr_hold = {mnr, 1'b0};
    seg_o.incr_step = {1'b0, mnr, 1'b0} - {1'b0, maj, 1'b0};
    seg_o.remaining = maj;
    seg_o.x_major   = x_maj;
    seg_o.x_dir_neg = x_neg;
    seg_o.y_dir_neg = y_neg;
    seg_o.active    = maj != '0;
  end

endmodule

`default_nettype wire

FILE: sv/brl_core.sv
// Segment state registers and the per-pixel Bresenham step.
`default_nettype none

module brl_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  brl_pkg::in_req_t   req_i,
  output logic               emit_o,
  output brl_pkg::out_req_t  pixel_o
);

  localparam int unsigned CW = brl_pkg::COORD_BITS;
  localparam int unsigned DW = brl_pkg::DEC_BITS;

  brl_pkg::seg_state_t seg_q, seg_d, seg_load;
  logic                is_step, minor_moves;
  logic signed [CW-1:0] x_inc, y_inc;

  brl_setup u_setup (
    .req_i (req_i),
    .seg_o (seg_load)
  );

  assign is_step     = req_i.action == brl_pkg::ACT_STEP;
  assign emit_o      = is_step && seg_q.active;
  assign minor_moves = !seg_q.decision[DW-1] && (seg_q.decision != '0);
  assign x_inc       = seg_q.x_dir_neg ? '1 : CW'(1);
  assign y_inc       = seg_q.y_dir_neg ? '1 : CW'(1);

  always_comb begin
    pixel_o.pixel_x = seg_q.cur_x;
    pixel_o.pixel_y = seg_q.cur_y;
    pixel_o.last    = seg_q.remaining == CW'(1);
  end

  always_comb begin
    seg_d = seg_q;
    if (!is_step) begin
      seg_d = seg_load;
    end else if (seg_q.active) begin
      if (seg_q.x_major || minor_moves) begin
        seg_d.cur_x = seg_q.cur_x + x_inc;
      end
      if (!seg_q.x_major || minor_moves) begin
        seg_d.cur_y = seg_q.cur_y + y_inc;
      end
      if (minor_moves) begin
        seg_d.decision = seg_q.decision + {{(DW-brl_pkg::STEP_BITS){seg_q.incr_step[
          brl_pkg::STEP_BITS-1]}}, seg_q.incr_step};
      end else begin
        seg_d.decision = seg_q.decision + {{(DW-brl_pkg::HOLD_BITS){1'b0}}, seg_q.incr_hold};
      end
      seg_d.remaining = seg_q.remaining - CW'(1);
      seg_d.active    = seg_q.remaining != CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= '0;
    end else if (fire_i) begin
      seg_q <= seg_d;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && emit_o && pixel_o.last |=> !seg_q.active)
    else $error("Segment still active after its last pixel.");

  a_idle_step_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_step && !seg_q.active |=> $stable(seg_q))
    else $error("Step without a segment changed the state.");
`endif

endmodule

`default_nettype wire
